@@ hw/rtl/tngen_pkg.sv @@
// Shared types, constants and helpers for the triangle tangent/normal generator.
// Used by triangle_tangent_normal_gen and its port checker; no dependencies.
`timescale 1ns / 1ps

package tngen_pkg;

    localparam int FRAC_BITS   = 16;
    localparam int COORD_WIDTH = 32;

    // values per corner: pos x,y,z, normal x,y,z, u, flipped v
    localparam int VALS        = 8;
    localparam int V_PX        = 0;
    localparam int V_NX        = 3;
    localparam int V_U         = 6;
    localparam int V_V         = 7;

    localparam int EW          = COORD_WIDTH + 1;          // exact difference width
    localparam int SH_W        = $clog2(EW + 1);
    localparam int MAG_W       = 30;                       // shrunk / normalized magnitude bits
    localparam int LEN_W       = MAG_W + 2;                // sqrt of a sum of three squares
    localparam int NUM_W       = MAG_W + FRAC_BITS + 1;    // divide numerator
    localparam int SQRT_ITERS  = 32;
    localparam int CNT_W       = $clog2((NUM_W > SQRT_ITERS) ? NUM_W : SQRT_ITERS);

    localparam int IN_TDATA_W  = VALS * COORD_WIDTH;
    localparam int IN_TUSER_W  = 2;
    localparam int OUT_FIELDS  = 11 * COORD_WIDTH;
    localparam int OUT_TDATA_W = ((OUT_FIELDS + 7) / 8) * 8;

    // tuser bits on the input side
    localparam int U_HAS_NORMAL = 0;
    localparam int U_HAS_UV     = 1;

    // product program: dets, tangent rows, face normal rows
    localparam logic [3:0] MI_DET_LAST   = 4'd1;
    localparam logic [3:0] MI_TAN_LAST   = 4'd7;
    localparam logic [3:0] MI_FACE_FIRST = 4'd8;
    localparam logic [3:0] MI_FACE_LAST  = 4'd13;

    typedef logic signed [COORD_WIDTH-1:0] coord_t;
    typedef logic [VALS-1:0][COORD_WIDTH-1:0] corner_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_EDGE,
        ST_SHRINK,
        ST_MUL,
        ST_ACC,
        ST_UMAG,
        ST_NORM,
        ST_SQ_MUL,
        ST_SQ_ACC,
        ST_SQRT,
        ST_DIV_INIT,
        ST_DIV,
        ST_LOAD,
        ST_WAIT
    } state_t;

    function automatic coord_t sat_coord(input logic signed [63:0] v);
        logic signed [63:0] hi;
        logic signed [63:0] lo;
        hi = (64'sd1 <<< (COORD_WIDTH - 1)) - 64'sd1;
        lo = -hi - 64'sd1;
        if (v > hi) begin
            sat_coord = hi[COORD_WIDTH-1:0];
        end else if (v < lo) begin
            sat_coord = lo[COORD_WIDTH-1:0];
        end else begin
            sat_coord = v[COORD_WIDTH-1:0];
        end
    endfunction

endpackage

@@ hw/rtl/triangle_tangent_normal_gen.sv @@
// Per-triangle tangent and face normal generator around one shared 32x32 multiplier,
// a one-bit-per-cycle square root and a restoring divider. Depends on tngen_pkg.
// Corners one and two are stored and emit nothing. For the third corner the determinant
// comes first; with it zero and a normal supplied, output follows; else each of at most two
// normalizations runs a scaling loop, 32 sqrt steps and three divides,
// then three beats leave one at a time, each held until it is taken.
// s_tready is low from the third corner until its last beat is taken.
// Reset (aresetn low, synchronous) empties the corner count and clears m_tvalid.
`timescale 1ns / 1ps

module triangle_tangent_normal_gen (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // pos_x, pos_y, pos_z, norm_x, norm_y, norm_z, tex_u, tex_v
    input  logic [tngen_pkg::IN_TDATA_W-1:0]  s_tdata,
    // has_normal, has_uv
    input  logic [tngen_pkg::IN_TUSER_W-1:0]  s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // out_pos_x/y/z, out_norm_x/y/z, out_tan_x/y/z, out_u, out_v
    output logic [tngen_pkg::OUT_TDATA_W-1:0] m_tdata,
    output logic                           m_tlast
);
    import tngen_pkg::*;

    state_t state_reg, state_next;
    logic [1:0] count_reg, count_next;
    logic       m_tvalid_reg, m_tvalid_next;

    corner_t c0_reg, c0_next, c1_reg, c1_next, c2_reg, c2_next;
    logic    has_n2_reg, has_n2_next;

    logic [5:0][EW-1:0] edge_reg, edge_next;
    logic [3:0][EW-1:0] duv_reg, duv_next;
    logic [3:0]         mul_idx_reg, mul_idx_next;
    logic signed [63:0] prod_reg, prod_next;
    logic signed [63:0] acc_reg, acc_next;
    logic               det_neg_reg, det_neg_next;
    logic [2:0][63:0]   vec_reg, vec_next;
    logic [2:0][63:0]   m_reg, m_next;
    logic               tan_sel_reg, tan_sel_next;
    logic [1:0]         comp_reg, comp_next;
    logic [63:0]        n_reg, n_next, res_reg, res_next, bit_reg, bit_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [LEN_W-1:0]   len_reg, len_next, rem_reg, rem_next;
    logic [NUM_W-1:0]   num_reg, num_next;
    logic [2:0][COORD_WIDTH-1:0] tan_reg, tan_next, fn_reg, fn_next;
    logic [1:0]         emit_reg, emit_next;
    logic [OUT_TDATA_W-1:0] tdata_reg, tdata_next;
    logic               tlast_reg, tlast_next;

    logic signed [63:0] acc_diff;
    logic [63:0]        or_m;
    logic               face_need, vec_zero, norm_hi, norm_lo;
    logic               sqrt_last, div_last, unit_last;
    logic signed [31:0] mul_a, mul_b;
    corner_t            cur;

    assign acc_diff  = acc_reg - prod_reg;
    assign or_m      = m_reg[0] | m_reg[1] | m_reg[2];
    assign face_need = !has_n2_reg;
    assign vec_zero  = (vec_reg == '0);
    assign norm_hi   = (or_m >= (64'd1 << MAG_W));
    assign norm_lo   = (or_m < (64'd1 << (MAG_W - 1)));
    assign sqrt_last = (cnt_reg == CNT_W'(SQRT_ITERS - 1));
    assign div_last  = (cnt_reg == CNT_W'(NUM_W - 1));
    assign unit_last = (comp_reg == 2'd2);

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = tdata_reg;
    assign m_tlast  = tlast_reg;

    // incoming corner with absent attributes zeroed and v flipped
    always_comb begin
        corner_t raw;
        raw = corner_t'(s_tdata);
        cur = raw;
        if (!s_tuser[U_HAS_NORMAL]) begin
            for (int i = 0; i < 3; i++) cur[V_NX + i] = '0;
        end
        if (s_tuser[U_HAS_UV]) begin
            cur[V_V] = sat_coord((64'sd1 <<< FRAC_BITS) - 64'(signed'(raw[V_V])));
        end else begin
            cur[V_U] = '0;
            cur[V_V] = '0;
        end
    end

    // shared multiplier operand select
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        if (state_reg == ST_SQ_MUL) begin
            mul_a = signed'(m_reg[comp_reg][31:0]);
            mul_b = signed'(m_reg[comp_reg][31:0]);
        end else begin
            case (mul_idx_reg)
                4'd0:  begin mul_a = signed'(duv_reg[0][31:0]);  mul_b = signed'(duv_reg[3][31:0]);  end
                4'd1:  begin mul_a = signed'(duv_reg[2][31:0]);  mul_b = signed'(duv_reg[1][31:0]);  end
                4'd2:  begin mul_a = signed'(duv_reg[3][31:0]);  mul_b = signed'(edge_reg[0][31:0]); end
                4'd3:  begin mul_a = signed'(duv_reg[1][31:0]);  mul_b = signed'(edge_reg[3][31:0]); end
                4'd4:  begin mul_a = signed'(duv_reg[3][31:0]);  mul_b = signed'(edge_reg[1][31:0]); end
                4'd5:  begin mul_a = signed'(duv_reg[1][31:0]);  mul_b = signed'(edge_reg[4][31:0]); end
                4'd6:  begin mul_a = signed'(duv_reg[3][31:0]);  mul_b = signed'(edge_reg[2][31:0]); end
                4'd7:  begin mul_a = signed'(duv_reg[1][31:0]);  mul_b = signed'(edge_reg[5][31:0]); end
                4'd8:  begin mul_a = signed'(edge_reg[1][31:0]); mul_b = signed'(edge_reg[5][31:0]); end
                4'd9:  begin mul_a = signed'(edge_reg[2][31:0]); mul_b = signed'(edge_reg[4][31:0]); end
                4'd10: begin mul_a = signed'(edge_reg[2][31:0]); mul_b = signed'(edge_reg[3][31:0]); end
                4'd11: begin mul_a = signed'(edge_reg[0][31:0]); mul_b = signed'(edge_reg[5][31:0]); end
                4'd12: begin mul_a = signed'(edge_reg[0][31:0]); mul_b = signed'(edge_reg[4][31:0]); end
                4'd13: begin mul_a = signed'(edge_reg[1][31:0]); mul_b = signed'(edge_reg[3][31:0]); end
                default: begin mul_a = '0; mul_b = '0; end
            endcase
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:     if (s_tvalid && count_reg == 2'd2) state_next = ST_EDGE;
            ST_EDGE:     state_next = ST_SHRINK;
            ST_SHRINK:   state_next = ST_MUL;
            ST_MUL:      state_next = ST_ACC;
            ST_ACC: begin
                if (!mul_idx_reg[0]) begin
                    state_next = ST_MUL;
                end else if (mul_idx_reg == MI_DET_LAST) begin
                    if (acc_diff != 0 || face_need) state_next = ST_MUL;
                    else state_next = ST_LOAD;
                end else if (mul_idx_reg == MI_TAN_LAST || mul_idx_reg == MI_FACE_LAST) begin
                    state_next = ST_UMAG;
                end else begin
                    state_next = ST_MUL;
                end
            end
            ST_UMAG: begin
                if (!vec_zero) state_next = ST_NORM;
                else if (tan_sel_reg && face_need) state_next = ST_MUL;
                else state_next = ST_LOAD;
            end
            ST_NORM:     if (!norm_hi && !norm_lo) state_next = ST_SQ_MUL;
            ST_SQ_MUL:   state_next = ST_SQ_ACC;
            ST_SQ_ACC:   state_next = unit_last ? ST_SQRT : ST_SQ_MUL;
            ST_SQRT:     if (sqrt_last) state_next = ST_DIV_INIT;
            ST_DIV_INIT: state_next = ST_DIV;
            ST_DIV: begin
                if (div_last) begin
                    if (!unit_last) state_next = ST_DIV_INIT;
                    else if (tan_sel_reg && face_need) state_next = ST_MUL;
                    else state_next = ST_LOAD;
                end
            end
            ST_LOAD:     state_next = ST_WAIT;
            ST_WAIT: begin
                if (m_tready) state_next = (emit_reg == 2'd2) ? ST_IDLE : ST_LOAD;
            end
            default:     state_next = ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        logic [EW-1:0]    mg;
        logic [EW-1:0]    or_e;
        logic [EW-1:0]    or_d;
        logic [SH_W-1:0]  sh_e;
        logic [SH_W-1:0]  sh_d;
        logic [EW-1:0]    q_e;
        logic [63:0]      rb;
        logic [LEN_W:0]   rem_sh;
        logic             ge;
        logic [NUM_W-1:0] q_full;
        logic signed [63:0] q_s;
        coord_t           rv;
        corner_t          ck;

        count_next    = count_reg;
        m_tvalid_next = m_tvalid_reg;
        c0_next       = c0_reg;
        c1_next       = c1_reg;
        c2_next       = c2_reg;
        has_n2_next   = has_n2_reg;
        edge_next     = edge_reg;
        duv_next      = duv_reg;
        mul_idx_next  = mul_idx_reg;
        prod_next     = prod_reg;
        acc_next      = acc_reg;
        det_neg_next  = det_neg_reg;
        vec_next      = vec_reg;
        m_next        = m_reg;
        tan_sel_next  = tan_sel_reg;
        comp_next     = comp_reg;
        n_next        = n_reg;
        res_next      = res_reg;
        bit_next      = bit_reg;
        cnt_next      = cnt_reg;
        len_next      = len_reg;
        rem_next      = rem_reg;
        num_next      = num_reg;
        tan_next      = tan_reg;
        fn_next       = fn_reg;
        emit_next     = emit_reg;
        tdata_next    = tdata_reg;
        tlast_next    = tlast_reg;
        or_e = '0; or_d = '0; sh_e = '0; sh_d = '0; mg = '0; q_e = '0;
        rb = '0; rem_sh = '0; ge = 1'b0; q_full = '0; q_s = '0; rv = '0; ck = c0_reg;

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    case (count_reg)
                        2'd0: begin c0_next = cur; count_next = 2'd1; end
                        2'd1: begin c1_next = cur; count_next = 2'd2; end
                        default: begin
                            c2_next      = cur;
                            count_next   = 2'd0;
                            has_n2_next  = s_tuser[U_HAS_NORMAL];
                            mul_idx_next = '0;
                            emit_next    = '0;
                        end
                    endcase
                end
            end
            ST_EDGE: begin
                for (int i = 0; i < 3; i++) begin
                    edge_next[i]     = EW'(signed'(c1_reg[V_PX + i])) - EW'(signed'(c0_reg[V_PX + i]));
                    edge_next[3 + i] = EW'(signed'(c2_reg[V_PX + i])) - EW'(signed'(c0_reg[V_PX + i]));
                end
                duv_next[0] = EW'(signed'(c1_reg[V_U])) - EW'(signed'(c0_reg[V_U]));
                duv_next[1] = EW'(signed'(c1_reg[V_V])) - EW'(signed'(c0_reg[V_V]));
                duv_next[2] = EW'(signed'(c2_reg[V_U])) - EW'(signed'(c0_reg[V_U]));
                duv_next[3] = EW'(signed'(c2_reg[V_V])) - EW'(signed'(c0_reg[V_V]));
            end
            ST_SHRINK: begin
                // one shift per group: smallest that puts every magnitude below 2^30
                for (int i = 0; i < 6; i++) begin
                    mg   = edge_reg[i][EW-1] ? -edge_reg[i] : edge_reg[i];
                    or_e = or_e | mg;
                end
                for (int i = 0; i < 4; i++) begin
                    mg   = duv_reg[i][EW-1] ? -duv_reg[i] : duv_reg[i];
                    or_d = or_d | mg;
                end
                for (int s = EW; s >= 0; s--) begin
                    if (64'(or_e >> s) < (64'd1 << MAG_W)) sh_e = SH_W'(s);
                    if (64'(or_d >> s) < (64'd1 << MAG_W)) sh_d = SH_W'(s);
                end
                for (int i = 0; i < 6; i++) begin
                    mg  = edge_reg[i][EW-1] ? -edge_reg[i] : edge_reg[i];
                    q_e = mg >> sh_e;
                    edge_next[i] = edge_reg[i][EW-1] ? -q_e : q_e;
                end
                for (int i = 0; i < 4; i++) begin
                    mg  = duv_reg[i][EW-1] ? -duv_reg[i] : duv_reg[i];
                    q_e = mg >> sh_d;
                    duv_next[i] = duv_reg[i][EW-1] ? -q_e : q_e;
                end
            end
            ST_MUL: prod_next = mul_a * mul_b;
            ST_ACC: begin
                if (!mul_idx_reg[0]) begin
                    acc_next     = prod_reg;
                    mul_idx_next = mul_idx_reg + 4'd1;
                end else begin
                    mul_idx_next = mul_idx_reg + 4'd1;
                    case (mul_idx_reg[3:1])
                        3'd0: begin
                            det_neg_next = acc_diff[63];
                            if (acc_diff == 0) begin
                                tan_next     = '0;
                                mul_idx_next = MI_FACE_FIRST;
                            end
                        end
                        3'd1, 3'd4: vec_next[0] = acc_diff;
                        3'd2, 3'd5: vec_next[1] = acc_diff;
                        3'd3, 3'd6: vec_next[2] = acc_diff;
                        default: ;
                    endcase
                    tan_sel_next = (mul_idx_reg == MI_TAN_LAST);
                end
            end
            ST_UMAG: begin
                for (int i = 0; i < 3; i++) begin
                    m_next[i] = vec_reg[i][63] ? -vec_reg[i] : vec_reg[i];
                end
                comp_next = '0;
                if (vec_zero) begin
                    if (tan_sel_reg) tan_next = '0;
                    else fn_next = '0;
                    mul_idx_next = MI_FACE_FIRST;
                end
            end
            ST_NORM: begin
                for (int i = 0; i < 3; i++) begin
                    if (norm_hi) m_next[i] = m_reg[i] >> 1;
                    else if (norm_lo) m_next[i] = m_reg[i] << 1;
                end
            end
            ST_SQ_MUL: prod_next = mul_a * mul_b;
            ST_SQ_ACC: begin
                acc_next = ((comp_reg == 2'd0) ? 64'sd0 : acc_reg) + prod_reg;
                comp_next = comp_reg + 2'd1;
                if (unit_last) begin
                    n_next    = acc_next;
                    res_next  = '0;
                    bit_next  = 64'd1 << 62;
                    cnt_next  = '0;
                    comp_next = '0;
                end
            end
            ST_SQRT: begin
                rb = res_reg + bit_reg;
                if (n_reg >= rb) begin
                    n_next   = n_reg - rb;
                    res_next = (res_reg >> 1) + bit_reg;
                end else begin
                    res_next = res_reg >> 1;
                end
                bit_next = bit_reg >> 2;
                cnt_next = cnt_reg + CNT_W'(1);
                if (sqrt_last) len_next = res_next[LEN_W-1:0];
            end
            ST_DIV_INIT: begin
                // round to nearest: add half the length before dividing
                num_next = (NUM_W'(m_reg[comp_reg]) << FRAC_BITS) + NUM_W'(len_reg >> 1);
                rem_next = '0;
                cnt_next = '0;
            end
            ST_DIV: begin
                rem_sh   = {rem_reg, num_reg[NUM_W-1]};
                ge       = (rem_sh >= {1'b0, len_reg});
                rem_next = ge ? LEN_W'(rem_sh - {1'b0, len_reg}) : LEN_W'(rem_sh);
                num_next = {num_reg[NUM_W-2:0], ge};
                cnt_next = cnt_reg + CNT_W'(1);
                if (div_last) begin
                    q_full = num_next;
                    q_s    = vec_reg[comp_reg][63] ? -64'(q_full) : 64'(q_full);
                    rv     = sat_coord(q_s);
                    if (tan_sel_reg) begin
                        tan_next[comp_reg] = det_neg_reg ? -rv : rv;
                    end else begin
                        fn_next[comp_reg] = rv;
                    end
                    comp_next    = comp_reg + 2'd1;
                    mul_idx_next = MI_FACE_FIRST;
                end
            end
            ST_LOAD: begin
                case (emit_reg)
                    2'd0:    ck = c0_reg;
                    2'd1:    ck = c1_reg;
                    default: ck = c2_reg;
                endcase
                if (face_need) begin
                    for (int i = 0; i < 3; i++) ck[V_NX + i] = fn_reg[i];
                end
                tdata_next = '0;
                tdata_next[OUT_FIELDS-1:0] = {ck[V_V], ck[V_U], tan_reg[2], tan_reg[1],
                                              tan_reg[0], ck[V_NX+2], ck[V_NX+1], ck[V_NX],
                                              ck[V_PX+2], ck[V_PX+1], ck[V_PX]};
                tlast_next    = (emit_reg == 2'd2);
                m_tvalid_next = 1'b1;
            end
            ST_WAIT: begin
                if (m_tready) begin
                    m_tvalid_next = 1'b0;
                    emit_next     = emit_reg + 2'd1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        c0_reg      <= c0_next;
        c1_reg      <= c1_next;
        c2_reg      <= c2_next;
        has_n2_reg  <= has_n2_next;
        edge_reg    <= edge_next;
        duv_reg     <= duv_next;
        mul_idx_reg <= mul_idx_next;
        prod_reg    <= prod_next;
        acc_reg     <= acc_next;
        det_neg_reg <= det_neg_next;
        vec_reg     <= vec_next;
        m_reg       <= m_next;
        tan_sel_reg <= tan_sel_next;
        comp_reg    <= comp_next;
        n_reg       <= n_next;
        res_reg     <= res_next;
        bit_reg     <= bit_next;
        cnt_reg     <= cnt_next;
        len_reg     <= len_next;
        rem_reg     <= rem_next;
        num_reg     <= num_next;
        tan_reg     <= tan_next;
        fn_reg      <= fn_next;
        emit_reg    <= emit_next;
        tdata_reg   <= tdata_next;
        tlast_reg   <= tlast_next;
    end

endmodule

@@ hw/rtl/tngen_chk.sv @@
// Port-level checker for triangle_tangent_normal_gen, bound to the top level.
// Depends on tngen_pkg for port widths.
`timescale 1ns / 1ps

module tngen_chk (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              s_tready,
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic [tngen_pkg::OUT_TDATA_W-1:0] m_tdata,
    input logic                              m_tlast
);
    import tngen_pkg::*;

    // one triangle in flight: no input taken while a result beat is out
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid))
        else $error("input ready while result pending");

    a_idle_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && m_tlast) |=> (!m_tvalid && s_tready))
        else $error("block not idle after last beat");

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)))
        else $error("stalled result beat changed");

    a_reset_state: assert property (@(posedge aclk)
        !aresetn |=> (s_tready && !m_tvalid))
        else $error("reset did not return block to idle");

endmodule

bind triangle_tangent_normal_gen tngen_chk u_tngen_chk (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
